### rtl/rcfe_pkg.sv
// Shared types, field widths and codes for the route cache with FIFO eviction.
package rcfe_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int CMD_W      = 2;
  localparam int KEY_W      = 64;
  localparam int SLOT_W     = 6;
  localparam int EXP_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int MAXE_W     = 7;
  localparam int LIFE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME    = 2'd1;

  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 7'd64;
  localparam logic [LIFE_W-1:0] LIFETIME_RST    = 16'd30;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  dest_addr;
    logic [SLOT_W-1:0] entry_slot;
    logic [EXP_W-1:0]  now;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   hit_slot;
    logic                expired;
    logic                evicted;
    logic [SLOT_W-1:0]   evicted_slot;
  } rsp_t;

  typedef struct packed {
    logic [MAXE_W-1:0] max_entries;
    logic [LIFE_W-1:0] lifetime_ticks;
  } cfg_t;

endpackage

### rtl/rcfe_mem.sv
// Single-port-write, single-port-read entry memory with registered read data.
module rcfe_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rcfe_cfg.sv
// Configuration register file holding the entry limit and the entry lifetime.
module rcfe_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcfe_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [rcfe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rcfe_pkg::cfg_t                   cfg
);
  import rcfe_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_entries    <= MAX_ENTRIES_RST;
      cfg_r.lifetime_ticks <= LIFETIME_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_MAX_ENTRIES: begin
          if (cfg_wdata[MAXE_W-1:0] != '0) begin
            cfg_r.max_entries <= cfg_wdata[MAXE_W-1:0];
          end
        end
        CFG_LIFETIME: begin
          cfg_r.lifetime_ticks <= cfg_wdata[LIFE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

endmodule

### rtl/route_cache_fifo_evict_unit.sv
// Route cache top level: request sequencer that walks the entry memory once per lookup, insert
// or remove of a valid slot; remove first reads the named slot, and a remove of an empty slot
// or an unused command answers without a walk. One request is in work at a time: the next is
// taken once the last result is in the output register, and a lookup or insert is bound by the
// walk over every entry through the single read port.
// After reset a clearing pass invalidates every entry; cfg writes are taken.
module route_cache_fifo_evict_unit #(
  parameter int ENTRIES = rcfe_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rcfe_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rcfe_pkg::rsp_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcfe_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rcfe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rcfe_pkg::*;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RANK_W  = IDX_W;
  localparam int EXP_LO  = KEY_W;
  localparam int RANK_LO = KEY_W + EXP_W;
  localparam int WORD_W  = 1 + RANK_W + EXP_W + KEY_W;
  localparam int VLD_BIT = WORD_W - 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);
  localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PROBE, ST_PROBE_CHK, ST_SCAN, ST_FINISH, ST_RESP
  } state_t;

  state_t              state_r;
  req_t                req_r;
  rsp_t                pend_r;
  rsp_t                out_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    scan_r;
  logic [CNT_W-1:0]    count_r;
  logic                p_vld_r;
  logic [IDX_W-1:0]    p_idx_r;
  logic                found_r;
  logic [RANK_W-1:0]   best_rank_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [EXP_W-1:0]    best_exp_r;
  logic                drop_en_r;
  logic [RANK_W-1:0]   drop_rank_r;
  logic                dropped_r;
  logic [IDX_W-1:0]    drop_idx_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;

  cfg_t                cfg;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [WORD_W-1:0]   rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [WORD_W-1:0]   wr_data;

  logic                e_valid;
  logic [RANK_W-1:0]   e_rank;
  logic [EXP_W-1:0]    e_exp;
  logic [KEY_W-1:0]    e_key;
  logic                drop_hit;
  logic                dec_hit;
  logic                is_free;
  logic                key_hit;
  logic                evict_need;
  logic                slot_ok;
  logic [CNT_W-1:0]    cnt_after;
  logic [EXP_W:0]      exp_sum;
  logic [EXP_W-1:0]    exp_sat;

  rcfe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcfe_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign e_valid = rd_data[VLD_BIT];
  assign e_rank  = rd_data[RANK_LO +: RANK_W];
  assign e_exp   = rd_data[EXP_LO +: EXP_W];
  assign e_key   = rd_data[KEY_W-1:0];

  assign drop_hit = p_vld_r && drop_en_r && e_valid && (e_rank == drop_rank_r);
  assign dec_hit  = p_vld_r && drop_en_r && e_valid && (e_rank > drop_rank_r);
  assign is_free  = p_vld_r && (!e_valid || drop_hit);
  assign key_hit  = p_vld_r && (req_r.cmd == CMD_LOOKUP) && e_valid &&
                    (e_key == req_r.dest_addr) && (!found_r || (e_rank > best_rank_r));

  assign evict_need = (32'(count_r) >= 32'(cfg.max_entries)) ||
                      (32'(count_r) >= 32'(ENTRIES));
  assign slot_ok    = (32'(req_r.entry_slot) < 32'(ENTRIES));

  assign cnt_after = count_r - {{(CNT_W-1){1'b0}}, dropped_r};
  assign exp_sum   = {1'b0, req_r.now} + {{(EXP_W+1-LIFE_W){1'b0}}, cfg.lifetime_ticks};
  assign exp_sat   = exp_sum[EXP_W] ? {EXP_W{1'b1}} : exp_sum[EXP_W-1:0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_r[IDX_W-1:0];
    if (state_r == ST_PROBE) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(req_r.entry_slot);
    end else if (state_r == ST_SCAN && scan_r != LAST_CNT) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx_r;
    wr_data = rd_data;
    priority if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = scan_r[IDX_W-1:0];
      wr_data = '0;
    end else if (drop_hit) begin
      wr_en            = 1'b1;
      wr_data[VLD_BIT] = 1'b0;
    end else if (dec_hit) begin
      wr_en                       = 1'b1;
      wr_data[RANK_LO +: RANK_W] = e_rank - 1'b1;
    end else if (state_r == ST_FINISH && req_r.cmd == CMD_INSERT) begin
      wr_en   = 1'b1;
      wr_addr = free_idx_r;
      wr_data = {1'b1, RANK_W'(cnt_after), exp_sat, req_r.dest_addr};
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      scan_r       <= '0;
      count_r      <= '0;
      p_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      drop_en_r    <= 1'b0;
      dropped_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (scan_r == CLR_LAST) begin
            scan_r  <= '0;
            state_r <= ST_IDLE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_r        <= in_data;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            dropped_r    <= 1'b0;
            drop_en_r    <= (in_data.cmd == CMD_INSERT) && evict_need;
            drop_rank_r  <= '0;
            scan_r       <= '0;
            priority if (in_data.cmd == CMD_LOOKUP) begin
              state_r <= ST_SCAN;
            end else if (in_data.cmd == CMD_INSERT) begin
              state_r <= ST_SCAN;
            end else if (in_data.cmd == CMD_REMOVE) begin
              state_r <= ST_PROBE;
            end else begin
              pend_r  <= '0;
              state_r <= ST_RESP;
            end
          end
        end
        ST_PROBE: begin
          state_r <= ST_PROBE_CHK;
        end
        ST_PROBE_CHK: begin
          if (slot_ok && e_valid) begin
            drop_en_r   <= 1'b1;
            drop_rank_r <= e_rank;
            state_r     <= ST_SCAN;
          end else begin
            pend_r  <= {STATUS_EMPTY, {(2*SLOT_W+2){1'b0}}};
            state_r <= ST_RESP;
          end
        end
        ST_SCAN: begin
          if (scan_r != LAST_CNT) begin
            scan_r  <= scan_r + 1'b1;
            p_vld_r <= 1'b1;
            p_idx_r <= scan_r[IDX_W-1:0];
          end else begin
            p_vld_r <= 1'b0;
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          unique case (req_r.cmd)
            CMD_LOOKUP: begin
              pend_r <= {found_r ? STATUS_OK : STATUS_NOT_FOUND,
                         found_r ? SLOT_W'(hit_idx_r) : {SLOT_W{1'b0}},
                         found_r && (best_exp_r < req_r.now),
                         1'b0, {SLOT_W{1'b0}}};
            end
            CMD_INSERT: begin
              pend_r  <= {STATUS_OK, SLOT_W'(free_idx_r), 1'b0, dropped_r,
                          dropped_r ? SLOT_W'(drop_idx_r) : {SLOT_W{1'b0}}};
              count_r <= cnt_after + 1'b1;
            end
            CMD_REMOVE: begin
              pend_r  <= {STATUS_OK, {(2*SLOT_W+2){1'b0}}};
              count_r <= cnt_after;
            end
            default: begin
              pend_r <= '0;
            end
          endcase
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r       <= pend_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (key_hit) begin
        found_r     <= 1'b1;
        best_rank_r <= e_rank;
        hit_idx_r   <= p_idx_r;
        best_exp_r  <= e_exp;
      end
      if (drop_hit) begin
        dropped_r  <= 1'b1;
        drop_idx_r <= p_idx_r;
      end
      if (is_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= p_idx_r;
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(ENTRIES))
    else $error("entry count exceeds capacity");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && req_r.cmd == CMD_INSERT) |-> free_found_r)
    else $error("insert finished without a free slot");

  a_drop_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && drop_en_r) |-> dropped_r)
    else $error("eviction or remove pass dropped no entry");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("memory read and write hit the same entry in one cycle");

endmodule

### verif/tb.sv
// Self-checking testbench for the route cache unit: directed and random requests against a cache model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfe_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int KEY_POOL_N = 16;
  localparam int REPORT_MAX = 10;
  localparam logic [KEY_W-1:0] KEY_A = 64'hA5A5_5A5A_0F0F_F0F0;
  localparam logic [KEY_W-1:0] KEY_B = 64'h5A5A_A5A5_F0F0_0F0F;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  rsp_t pending_rsp[$];

  logic [KEY_W-1:0] cache_key [ENTRIES];
  logic [EXP_W-1:0] cache_expiry [ENTRIES];
  bit cache_valid [ENTRIES];
  int cache_rank [ENTRIES];
  int cache_count;
  int limit_entries;
  logic [LIFE_W-1:0] lifetime;

  logic [KEY_W-1:0] key_pool [KEY_POOL_N];
  logic [EXP_W-1:0] tick = '0;

  route_cache_fifo_evict_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("route_cache_fifo_evict_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("result with no request pending: %h", out_data);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.status !== want.status || out_data.hit_slot !== want.hit_slot ||
            out_data.expired !== want.expired || out_data.evicted !== want.evicted ||
            out_data.evicted_slot !== want.evicted_slot) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch expected status=%0d hit_slot=%0d expired=%0d evicted=%0d ev_slot=%0d",
                     want.status, want.hit_slot, want.expired, want.evicted, want.evicted_slot);
            $display("         actual   status=%0d hit_slot=%0d expired=%0d evicted=%0d ev_slot=%0d",
                     out_data.status, out_data.hit_slot, out_data.expired, out_data.evicted,
                     out_data.evicted_slot);
          end
        end
      end
    end
  end

  function automatic void cache_drop(int slot);
    int i;
    int r;
    r = cache_rank[slot];
    cache_valid[slot] = 1'b0;
    for (i = 0; i < ENTRIES; i++)
      if (cache_valid[i] && cache_rank[i] > r) cache_rank[i]--;
    if (cache_count > 0) cache_count--;
  endfunction

  function automatic rsp_t cache_apply(req_t r);
    rsp_t rsp;
    bit found;
    int i;
    int best;
    logic [EXP_W:0] sum;
    rsp = '0;
    rsp.status = STATUS_OK;
    found = 1'b0;
    best = 0;
    case (r.cmd)
      CMD_LOOKUP: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (cache_valid[i] && cache_key[i] == r.dest_addr &&
              (!found || cache_rank[i] > best)) begin
            found = 1'b1;
            best = cache_rank[i];
            rsp.hit_slot = SLOT_W'(i);
          end
        end
        if (found) rsp.expired = cache_expiry[rsp.hit_slot] < r.now;
        else rsp.status = STATUS_NOT_FOUND;
      end
      CMD_INSERT: begin
        if (cache_count >= limit_entries || cache_count >= ENTRIES) begin
          for (i = 0; i < ENTRIES && !rsp.evicted; i++) begin
            if (cache_valid[i] && cache_rank[i] == 0) begin
              rsp.evicted = 1'b1;
              rsp.evicted_slot = SLOT_W'(i);
              cache_drop(i);
            end
          end
        end
        i = 0;
        while (i < ENTRIES && cache_valid[i]) i++;
        if (i >= ENTRIES) i = 0;
        sum = {1'b0, r.now} + {{(EXP_W+1-LIFE_W){1'b0}}, lifetime};
        cache_key[i] = r.dest_addr;
        cache_expiry[i] = sum[EXP_W] ? '1 : sum[EXP_W-1:0];
        cache_rank[i] = cache_count;
        cache_valid[i] = 1'b1;
        cache_count++;
        rsp.hit_slot = SLOT_W'(i);
      end
      CMD_REMOVE: begin
        if (cache_valid[r.entry_slot]) cache_drop(int'(r.entry_slot));
        else rsp.status = STATUS_EMPTY;
      end
      default: rsp = '0;
    endcase
    return rsp;
  endfunction

  function automatic req_t make_req(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                    logic [SLOT_W-1:0] slot, logic [EXP_W-1:0] now);
    req_t r;
    r.cmd = cmd;
    r.dest_addr = key;
    r.entry_slot = slot;
    r.now = now;
    return r;
  endfunction

  function automatic req_t random_req(int ins_pct, int rem_pct);
    req_t r;
    int pick;
    int s;
    int k;
    bit placed;
    pick = $urandom_range(99);
    if (pick < 3) tick = $urandom;
    else if (pick < 5) tick = 32'hFFFF_FFFF - $urandom_range(40);
    else tick = tick + $urandom_range(4);
    if ($urandom_range(99) == 0) key_pool[$urandom_range(KEY_POOL_N-1)] = {$urandom, $urandom};
    r.now = tick;
    r.dest_addr = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_N-1)]
                                             : {$urandom, $urandom};
    r.entry_slot = SLOT_W'($urandom_range(ENTRIES-1));
    pick = $urandom_range(99);
    if (pick < 2) r.cmd = CMD_UNUSED;
    else if (pick < 2 + ins_pct) r.cmd = CMD_INSERT;
    else if (pick < 2 + ins_pct + rem_pct) r.cmd = CMD_REMOVE;
    else r.cmd = CMD_LOOKUP;
    if (r.cmd == CMD_REMOVE && cache_count > 0 && $urandom_range(99) < 75) begin
      s = $urandom_range(ENTRIES-1);
      placed = 1'b0;
      for (k = 0; k < ENTRIES && !placed; k++) begin
        if (cache_valid[(s + k) % ENTRIES]) begin
          r.entry_slot = SLOT_W'((s + k) % ENTRIES);
          placed = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_rsp.push_back(cache_apply(r));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MAX_ENTRIES: if (data[MAXE_W-1:0] != '0) limit_entries = int'(data[MAXE_W-1:0]);
      CFG_LIFETIME: lifetime = data[LIFE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_basic_ops();
    tx_idle_pct = 26;
    rx_stall_pct = 26;
    send_req(make_req(CMD_LOOKUP, '1, '0, '0));
    send_req(make_req(CMD_REMOVE, '0, '1, '0));
    send_req(make_req(CMD_UNUSED, '1, '1, '1));
    send_req(make_req(CMD_INSERT, '0, '1, '0));
    send_req(make_req(CMD_INSERT, '1, '0, '1));
    send_req(make_req(CMD_INSERT, '0, 6'd17, 32'd5));
    send_req(make_req(CMD_LOOKUP, '0, '1, 32'd100));
    send_req(make_req(CMD_LOOKUP, '0, '0, 32'd35));
    send_req(make_req(CMD_LOOKUP, '1, '0, '1));
    wait_drained();
    send_req(make_req(CMD_REMOVE, KEY_A, 6'd2, '0));
    send_req(make_req(CMD_LOOKUP, '0, '0, '0));
    send_req(make_req(CMD_REMOVE, '0, 6'd2, '1));
    send_req(make_req(CMD_INSERT, KEY_A, '0, 32'd1));
    send_req(make_req(CMD_LOOKUP, KEY_B, '0, 32'd1));
  endtask

  task automatic test_expiry_lifetime();
    wait_drained();
    cfg_write(CFG_LIFETIME, 16'd0);
    send_req(make_req(CMD_INSERT, KEY_B, '0, 32'd1000));
    send_req(make_req(CMD_LOOKUP, KEY_B, '0, 32'd1000));
    send_req(make_req(CMD_LOOKUP, KEY_B, '0, 32'd1001));
    wait_drained();
    cfg_write(CFG_LIFETIME, 16'hFFFF);
    send_req(make_req(CMD_INSERT, KEY_A, '0, 32'hFFFF_0001));
    send_req(make_req(CMD_INSERT, KEY_B, '0, 32'hFFFF_0000));
    send_req(make_req(CMD_LOOKUP, KEY_A, '0, '1));
  endtask

  task automatic test_eviction_limits();
    wait_drained();
    cfg_write(CFG_MAX_ENTRIES, 16'hFF81);
    cfg_write(CFG_SPARE_A, CFG_DATA_W'($urandom));
    cfg_write(CFG_SPARE_B, CFG_DATA_W'($urandom));
    send_req(make_req(CMD_INSERT, KEY_A, '0, 32'd7));
    send_req(make_req(CMD_INSERT, KEY_B, '0, 32'd8));
    wait_drained();
    cfg_write(CFG_MAX_ENTRIES, 16'h0000);
    send_req(make_req(CMD_INSERT, '1, '0, 32'd9));
    send_req(make_req(CMD_LOOKUP, '0, '0, 32'd9));
  endtask

  task automatic run_phase(int n, int tx, int rx, int max_e, int life, int ins_pct, int rem_pct);
    int k;
    wait_drained();
    cfg_write(CFG_MAX_ENTRIES, CFG_DATA_W'(max_e));
    cfg_write(CFG_LIFETIME, CFG_DATA_W'(life));
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(199) == 0) wait_drained();
      send_req(random_req(ins_pct, rem_pct));
    end
  endtask

  task automatic test_random_traffic();
    run_phase(250, 0, 0, 64, 30, 45, 15);
    run_phase(250, 81, 0, 8, 0, 40, 15);
    run_phase(250, 0, 81, 127, 65535, 60, 5);
    run_phase(250, 26, 26, 5, 1000, 35, 10);
    run_phase(250, 0, 0, 1, 3, 40, 20);
    run_phase(250, 81, 0, 100, 12, 55, 10);
    run_phase(250, 0, 81, 2, 65534, 40, 25);
    run_phase(250, 26, 26, 64, 300, 45, 20);
  endtask

  initial begin
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i] = '0;
      cache_expiry[i] = '0;
      cache_rank[i] = 0;
    end
    cache_count = 0;
    limit_entries = int'(MAX_ENTRIES_RST);
    lifetime = LIFETIME_RST;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_expiry_lifetime();
    test_eviction_limits();
    test_random_traffic();
    wait_drained();
    repeat (100) @(posedge clk);
    if (pending_rsp.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("route_cache_fifo_evict_unit verification clean");
    end else begin
      $display("route_cache_fifo_evict_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/rcfe_pkg.sv
rtl/rcfe_mem.sv
rtl/rcfe_cfg.sv
rtl/route_cache_fifo_evict_unit.sv
verif/tb.sv
